@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the stop pairing block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define OPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define OPP_ASSERT_NEVER(lbl, cond, msg) \
  `OPP_ASSERT(lbl, !(cond), msg)

`endif

@@ sv/opp_pkg.sv @@
// Package: sizes, command codes and shared types of the stop pairing block
`default_nettype none

package opp_pkg;

  localparam int unsigned MAX_STOPS  = 1024;
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned NUM_CELLS  = 16;
  localparam int unsigned BANK_DEPTH = MAX_STOPS / NUM_CELLS;
  localparam int unsigned CELL_BITS  = $clog2(NUM_CELLS);
  localparam int unsigned ROW_BITS   = $clog2(BANK_DEPTH);
  localparam int unsigned IDX_BITS   = $clog2(MAX_STOPS);
  localparam int unsigned CNT_BITS   = $clog2(MAX_STOPS + 1);
  localparam int unsigned FLIGHT_MAX = 2 * NUM_CELLS;
  localparam int unsigned FLIGHT_BITS = $clog2(FLIGHT_MAX + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } opp_cmd_e;

  typedef struct packed {
    logic [1:0]          mod3;
    logic [POS_BITS-1:0] pos;
  } opp_entry_t;

  typedef struct packed {
    logic                 en;
    logic [CELL_BITS-1:0] bank;
    logic [ROW_BITS-1:0]  row;
    opp_entry_t           data;
  } opp_wr_t;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [ROW_BITS-1:0] row;
    logic [POS_BITS-1:0] start;
    logic [1:0]          start_mod;
    logic                found;
    logic [POS_BITS-1:0] end_pos;
  } opp_wave_t;

endpackage

`default_nettype wire

@@ sv/opp_if.sv @@
// Interfaces: request and result channels of the stop pairing block
`default_nettype none

interface opp_in_if;
  import opp_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [POS_BITS-1:0] position;

  modport source (output valid, output command, output position, input ready);
  modport sink   (input valid, input command, input position, output ready);
endinterface

interface opp_out_if;
  import opp_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] start_pos;
  logic [POS_BITS-1:0] end_pos;
  logic                stop_found;

  modport source (output valid, output start_pos, output end_pos, output stop_found,
                  input ready);
  modport sink   (input valid, input start_pos, input end_pos, input stop_found,
                  output ready);
endinterface

`default_nettype wire

@@ sv/opp_cell.sv @@
// Search cell: one bank of stored stops, tests each passing wave against its entry
`default_nettype none

module opp_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [opp_pkg::CELL_BITS-1:0] cell_id_i,
  input  wire logic [opp_pkg::CNT_BITS-1:0]  count_i,
  input  wire opp_pkg::opp_wr_t              wr_i,
  input  wire opp_pkg::opp_wave_t            wave_i,
  output opp_pkg::opp_wave_t                 wave_o
);
  import opp_pkg::*;

  opp_entry_t          mem_q [BANK_DEPTH];
  opp_entry_t          rd_q;
  opp_wave_t           mid_q;
  opp_wave_t           out_q;
  opp_wave_t           out_d;
  logic [IDX_BITS-1:0] idx;
  logic                hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.bank == cell_id_i)) begin
      mem_q[wr_i.row] <= wr_i.data;
    end
    rd_q <= mem_q[wave_i.row];
  end

  assign idx = {mid_q.row, cell_id_i};
  assign hit = mid_q.valid && !mid_q.found && (CNT_BITS'(idx) < count_i)
               && (rd_q.pos > mid_q.start) && (rd_q.mod3 == mid_q.start_mod);

  always_comb begin
    out_d = mid_q;
    if (hit) begin
      out_d.found   = 1'b1;
      out_d.end_pos = rd_q.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
    end else begin
      mid_q <= wave_i;
      out_q <= out_d;
    end
  end

  assign wave_o = out_q;

endmodule

`default_nettype wire

@@ sv/orf_stop_pairing.sv @@
// Top level: stop list loading, query sequencing and the chain of search cells
//
//   channel   dir  handshake          payload
//   in_if     in   valid/ready        command, position
//   out_if    out  valid/ready        start_pos, end_pos, stop_found
//   cfg       in   cfg_we_i           cfg_wdata_i (sequence length)
//
// Clear empties the list; a load writes the next free bank slot.
// A query sends one wave per row of 16 stops through 16 cells of 2 stages each.
// An empty list skips the scan and goes straight to the result.
// Reset empties the list and zeroes the sequence length; stored values are not cleared.
// A result waits in the output register; clears and loads are still taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module orf_stop_pairing (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [opp_pkg::POS_BITS-1:0] cfg_wdata_i,
  opp_in_if.sink                            in_if,
  opp_out_if.source                         out_if
);
  import opp_pkg::*;

  localparam int unsigned POS_PAIRS = (POS_BITS + 1) / 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  function automatic logic [1:0] mod3(input logic [POS_BITS-1:0] v);
    logic [2*POS_PAIRS-1:0] ve;
    logic [7:0]             s1;
    logic [3:0]             s2;
    logic [2:0]             s3;
    logic [1:0]             r;
    ve = (2*POS_PAIRS)'(v);
    s1 = '0;
    for (int i = 0; i < POS_PAIRS; i++) begin
      s1 = s1 + 8'(ve[2*i +: 2]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]) + 4'(s1[7:6]);
    s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
    case (s3) inside
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  state_e                 state_q;
  logic [CNT_BITS-1:0]    count_q;
  logic [POS_BITS-1:0]    seq_len_q;
  logic [POS_BITS-1:0]    start_q;
  logic [1:0]             start_mod_q;
  logic [ROW_BITS-1:0]    row_q;
  logic                   issued_all_q;
  logic                   decided_q;
  logic                   found_q;
  logic [POS_BITS-1:0]    end_q;
  logic [FLIGHT_BITS-1:0] flight_q;
  logic                   out_valid_q;
  logic [POS_BITS-1:0]    out_start_q;
  logic [POS_BITS-1:0]    out_end_q;
  logic                   out_found_q;

  logic                   accept;
  opp_cmd_e               cmd;
  logic [CNT_BITS-1:0]    cnt_m1;
  logic [ROW_BITS-1:0]    last_row;
  logic                   issue;
  logic                   emerge;
  opp_wr_t                wr;
  opp_wave_t              wave_head;
  opp_wave_t              waves [NUM_CELLS+1];

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign cmd         = opp_cmd_e'(in_if.command);

  assign cnt_m1   = count_q - CNT_BITS'(1);
  assign last_row = cnt_m1[IDX_BITS-1:CELL_BITS];

  always_comb begin
    wr.en        = accept && (cmd == CMD_LOAD) && (count_q < CNT_BITS'(MAX_STOPS));
    wr.bank      = count_q[CELL_BITS-1:0];
    wr.row       = count_q[IDX_BITS-1:CELL_BITS];
    wr.data.mod3 = mod3(in_if.position);
    wr.data.pos  = in_if.position;
  end

  assign issue  = (state_q == ST_SCAN) && !issued_all_q && !decided_q;
  assign emerge = waves[NUM_CELLS].valid;

  always_comb begin
    wave_head.valid     = issue;
    wave_head.last      = (row_q == last_row);
    wave_head.row       = row_q;
    wave_head.start     = start_q;
    wave_head.start_mod = start_mod_q;
    wave_head.found     = 1'b0;
    wave_head.end_pos   = '0;
  end

  assign waves[0] = wave_head;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    opp_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CELL_BITS'(k)),
      .count_i   (count_q),
      .wr_i      (wr),
      .wave_i    (waves[k]),
      .wave_o    (waves[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      seq_len_q    <= '0;
      start_q      <= '0;
      start_mod_q  <= '0;
      row_q        <= '0;
      issued_all_q <= 1'b0;
      decided_q    <= 1'b0;
      found_q      <= 1'b0;
      end_q        <= '0;
      flight_q     <= '0;
      out_valid_q  <= 1'b0;
      out_start_q  <= '0;
      out_end_q    <= '0;
      out_found_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seq_len_q <= cfg_wdata_i;
      end
      flight_q <= flight_q + FLIGHT_BITS'(issue) - FLIGHT_BITS'(emerge);
      if (out_valid_q && out_if.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_CLEAR: count_q <= '0;
              CMD_LOAD: begin
                if (count_q < CNT_BITS'(MAX_STOPS)) begin
                  count_q <= count_q + CNT_BITS'(1);
                end
              end
              CMD_QUERY: begin
                start_q      <= in_if.position;
                start_mod_q  <= mod3(in_if.position);
                row_q        <= '0;
                issued_all_q <= 1'b0;
                decided_q    <= 1'b0;
                if (count_q == '0) begin
                  found_q <= 1'b0;
                  end_q   <= seq_len_q;
                  state_q <= ST_FINISH;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            row_q <= row_q + ROW_BITS'(1);
            if (row_q == last_row) begin
              issued_all_q <= 1'b1;
            end
          end
          if (emerge && !decided_q) begin
            if (waves[NUM_CELLS].found) begin
              decided_q <= 1'b1;
              found_q   <= 1'b1;
              end_q     <= waves[NUM_CELLS].end_pos;
            end else if (waves[NUM_CELLS].last) begin
              decided_q <= 1'b1;
              found_q   <= 1'b0;
              end_q     <= seq_len_q;
            end
          end
          if (decided_q && (flight_q == '0)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_start_q <= start_q;
            out_end_q   <= end_q;
            out_found_q <= found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.start_pos  = out_start_q;
  assign out_if.end_pos    = out_end_q;
  assign out_if.stop_found = out_found_q;

  `OPP_ASSERT(a_flight_bound, flight_q <= FLIGHT_BITS'(FLIGHT_MAX), "waves in flight exceed chain depth")
  `OPP_ASSERT(a_count_bound, count_q <= CNT_BITS'(MAX_STOPS), "stop count beyond capacity")
  `OPP_ASSERT(a_idle_drained, (state_q == ST_IDLE) |-> (flight_q == '0), "idle with waves in flight")
  `OPP_ASSERT_NEVER(a_found_after_start, out_valid_q && out_found_q && (out_end_q <= out_start_q), "found stop not after start")

endmodule

`default_nettype wire
